FILE: rtl/jte_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the job table engine.
// No dependencies; used by jte_cell and job_table_engine_core.
package jte_pkg;

  localparam int TABLE_DEPTH = 16;

  localparam int CMD_W = 3;
  localparam int PID_W = 22;
  localparam int JID_W = 5;
  localparam int RS_W  = 2;
  localparam int STS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_PID  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND_PID = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_JID = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_PID  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET_JID  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FG_QUERY = 3'd6;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd2;
  localparam logic [STS_W-1:0] STS_BAD_KEY   = 2'd3;

  // Run state codes.
  localparam logic [RS_W-1:0] RUN_FG = 2'd1;

  // Operation broadcast to every cell for the whole scan.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PID_W-1:0] pid;
    logic [JID_W-1:0] jid;
    logic [RS_W-1:0]  rs;
    logic [JID_W-1:0] next_jid;
  } op_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [PID_W-1:0] pid;
    logic [JID_W-1:0] jid;
    logic [RS_W-1:0]  rs;
    logic [JID_W-1:0] max_jid;
  } token_t;

endpackage

FILE: rtl/jte_cell.sv
`timescale 1ns / 1ps
// One table entry of the job table engine, with its share of the scan.
// Depends on jte_pkg for the operation and token types.
module jte_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  jte_pkg::op_t    op,
  input  jte_pkg::token_t tok_in,
  output jte_pkg::token_t tok_out
);

  logic [jte_pkg::PID_W-1:0] pid_r;
  logic [jte_pkg::JID_W-1:0] jid_r;
  logic [jte_pkg::RS_W-1:0]  rs_r;
  logic [jte_pkg::PID_W-1:0] pid_nxt;
  logic [jte_pkg::JID_W-1:0] jid_nxt;
  logic [jte_pkg::RS_W-1:0]  rs_nxt;
  jte_pkg::token_t           tok_r;
  jte_pkg::token_t           tok_nxt;
  logic                      match;
  logic                      hit;

  always_comb begin
    case (op.cmd)
      jte_pkg::CMD_ADD:      match = (pid_r == '0);
      jte_pkg::CMD_DEL_PID,
      jte_pkg::CMD_FIND_PID,
      jte_pkg::CMD_SET_PID:  match = (pid_r == op.pid);
      jte_pkg::CMD_FIND_JID,
      jte_pkg::CMD_SET_JID:  match = (jid_r == op.jid);
      jte_pkg::CMD_FG_QUERY: match = (rs_r == jte_pkg::RUN_FG);
      default:               match = 1'b0;
    endcase
  end

  // Only the first matching entry along the chain takes the operation.
  assign hit = tok_in.valid && !tok_in.found && match;

  always_comb begin
    pid_nxt = pid_r;
    jid_nxt = jid_r;
    rs_nxt  = rs_r;
    if (hit) begin
      case (op.cmd)
        jte_pkg::CMD_ADD: begin
          pid_nxt = op.pid;
          jid_nxt = op.next_jid;
          rs_nxt  = op.rs;
        end
        jte_pkg::CMD_DEL_PID: begin
          pid_nxt = '0;
          jid_nxt = '0;
          rs_nxt  = '0;
        end
        jte_pkg::CMD_SET_PID,
        jte_pkg::CMD_SET_JID: begin
          rs_nxt = op.rs;
        end
        default: begin
          rs_nxt = rs_r;
        end
      endcase
    end
  end

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.found = tok_in.found || hit;
    if (hit) begin
      // A delete reports the entry as it was; everything else as it becomes.
      if (op.cmd == jte_pkg::CMD_DEL_PID) begin
        tok_nxt.pid = pid_r;
        tok_nxt.jid = jid_r;
        tok_nxt.rs  = rs_r;
      end else begin
        tok_nxt.pid = pid_nxt;
        tok_nxt.jid = jid_nxt;
        tok_nxt.rs  = rs_nxt;
      end
    end
    if (jid_nxt > tok_in.max_jid) begin
      tok_nxt.max_jid = jid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_r       <= '0;
      jid_r       <= '0;
      rs_r        <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      pid_r <= pid_nxt;
      jid_r <= jid_nxt;
      rs_r  <= rs_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: rtl/job_table_engine_core.sv
`timescale 1ns / 1ps
// Top level of the job table engine: command control, next-job-id counter
// and the chain of entry cells. Depends on jte_pkg and jte_cell.
//
// Usage:
// The input channel (in_valid/in_ready) carries one command per transfer:
// in_command, in_proc_id, in_job_id and in_run_state. The result channel
// (out_valid/out_ready) carries exactly one result per command: out_status,
// out_proc_id, out_job_id and out_state; the entry fields are zero unless
// the status is ok.
// The table lives in a row of TABLE_DEPTH cells, one entry per cell. A
// command that needs the table sends a token down the row; each cell
// compares its entry in the cycle the token passes, the first match acts,
// and the token also gathers the largest job id left for a delete. Each
// cell registers the token, so a scanning command's result passes the
// start register, every cell register, the holding state and the output
// register. A command rejected up front (a key of zero or an unused
// command code) skips the scan and goes straight to the holding state.
// One command is handled at a time; in_ready is high only while the engine
// is idle, and it returns once the result is in the output register, so the
// next command can start while that result still waits for its transfer.
// If the receiver stalls, a finished result waits in a holding state until
// the output register is free. Reset empties every entry, sets the job id
// counter to one and leaves both channels empty.
module job_table_engine_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [jte_pkg::CMD_W-1:0] in_command,
  input  logic [jte_pkg::PID_W-1:0] in_proc_id,
  input  logic [jte_pkg::JID_W-1:0] in_job_id,
  input  logic [jte_pkg::RS_W-1:0]  in_run_state,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [jte_pkg::STS_W-1:0] out_status,
  output logic [jte_pkg::PID_W-1:0] out_proc_id,
  output logic [jte_pkg::JID_W-1:0] out_job_id,
  output logic [jte_pkg::RS_W-1:0]  out_state
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                state_r;
  logic [jte_pkg::CMD_W-1:0] cmd_r;
  logic [jte_pkg::PID_W-1:0] key_pid_r;
  logic [jte_pkg::JID_W-1:0] key_jid_r;
  logic [jte_pkg::RS_W-1:0]  rs_r;
  logic [jte_pkg::JID_W-1:0] next_jid_r;
  logic                      start_r;

  // Result waiting for the output register.
  logic [jte_pkg::STS_W-1:0] res_sts_r;
  logic [jte_pkg::PID_W-1:0] res_pid_r;
  logic [jte_pkg::JID_W-1:0] res_jid_r;
  logic [jte_pkg::RS_W-1:0]  res_rs_r;

  logic                      out_valid_r;
  logic [jte_pkg::STS_W-1:0] out_sts_r;
  logic [jte_pkg::PID_W-1:0] out_pid_r;
  logic [jte_pkg::JID_W-1:0] out_jid_r;
  logic [jte_pkg::RS_W-1:0]  out_rs_r;

  jte_pkg::op_t    op;
  jte_pkg::token_t tok [jte_pkg::TABLE_DEPTH+1];
  jte_pkg::token_t tok_end;

  logic                      in_fire;
  logic                      out_free;
  logic                      pid_key_cmd;
  logic                      jid_key_cmd;
  logic                      bad_key;
  logic [jte_pkg::JID_W-1:0] jid_inc;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign pid_key_cmd = (in_command == jte_pkg::CMD_ADD) ||
                       (in_command == jte_pkg::CMD_DEL_PID) ||
                       (in_command == jte_pkg::CMD_FIND_PID) ||
                       (in_command == jte_pkg::CMD_SET_PID);
  assign jid_key_cmd = (in_command == jte_pkg::CMD_FIND_JID) ||
                       (in_command == jte_pkg::CMD_SET_JID);
  assign bad_key = (pid_key_cmd && (in_proc_id == '0)) ||
                   (jid_key_cmd && (in_job_id == '0));

  assign jid_inc = next_jid_r + jte_pkg::JID_W'(1);

  assign op.cmd      = cmd_r;
  assign op.pid      = key_pid_r;
  assign op.jid      = key_jid_r;
  assign op.rs       = rs_r;
  assign op.next_jid = next_jid_r;

  // The token enters the first cell for one cycle, clean.
  always_comb begin
    tok[0]         = '0;
    tok[0].valid   = start_r;
  end

  for (genvar g = 0; g < jte_pkg::TABLE_DEPTH; g++) begin : g_cell
    jte_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  assign tok_end = tok[jte_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      next_jid_r  <= jte_pkg::JID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      // In the hold state a result refills the output register in the same
      // cycle the old one leaves, so valid is only dropped elsewhere.
      if (out_valid_r && out_ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r     <= in_command;
            key_pid_r <= in_proc_id;
            key_jid_r <= in_job_id;
            rs_r      <= in_run_state;
            res_pid_r <= '0;
            res_jid_r <= '0;
            res_rs_r  <= '0;
            if (bad_key) begin
              res_sts_r <= jte_pkg::STS_BAD_KEY;
              state_r   <= S_HOLD;
            end else if (pid_key_cmd || jid_key_cmd ||
                         (in_command == jte_pkg::CMD_FG_QUERY)) begin
              start_r <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              // Unused command code: nothing to look at.
              res_sts_r <= jte_pkg::STS_NOT_FOUND;
              state_r   <= S_HOLD;
            end
          end
        end
        S_SCAN: begin
          // The token start is a single-cycle pulse.
          start_r <= 1'b0;
          if (tok_end.valid) begin
            state_r <= S_HOLD;
            if (tok_end.found) begin
              res_sts_r <= jte_pkg::STS_OK;
              res_pid_r <= tok_end.pid;
              res_jid_r <= tok_end.jid;
              res_rs_r  <= tok_end.rs;
              if (cmd_r == jte_pkg::CMD_ADD) begin
                if (32'(jid_inc) > 32'(jte_pkg::TABLE_DEPTH)) begin
                  next_jid_r <= jte_pkg::JID_W'(1);
                end else begin
                  next_jid_r <= jid_inc;
                end
              end else if (cmd_r == jte_pkg::CMD_DEL_PID) begin
                next_jid_r <= tok_end.max_jid + jte_pkg::JID_W'(1);
              end
            end else if (cmd_r == jte_pkg::CMD_ADD) begin
              res_sts_r <= jte_pkg::STS_FULL;
            end else begin
              res_sts_r <= jte_pkg::STS_NOT_FOUND;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_sts_r   <= res_sts_r;
            out_pid_r   <= res_pid_r;
            out_jid_r   <= res_jid_r;
            out_rs_r    <= res_rs_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_sts_r;
  assign out_proc_id = out_pid_r;
  assign out_job_id  = out_jid_r;
  assign out_state   = out_rs_r;

endmodule
